>>> rtl/core/hpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package hpq_pkg;

   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_OUT_W = 9;
   localparam int CAP_W = 9;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
   localparam logic [VALUE_W-1:0] NO_VALUE = 32'hFFFF_FFFF;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_LD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_RESP
   } state_type;

endpackage

>>> rtl/core/hpq_store.sv
// Heap entry memory: one write port, two registered read ports.
module hpq_store #(
   parameter int DEPTH = 256,
   parameter int AW = 8
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [hpq_pkg::VALUE_W-1:0]  wr_data,
   input  logic [AW-1:0]                rd_addr_a,
   input  logic [AW-1:0]                rd_addr_b,
   output logic [hpq_pkg::VALUE_W-1:0]  rd_data_a,
   output logic [hpq_pkg::VALUE_W-1:0]  rd_data_b
);

   logic [hpq_pkg::VALUE_W-1:0] heap_mem_ff [DEPTH];
   logic [hpq_pkg::VALUE_W-1:0] rd_data_a_ff;
   logic [hpq_pkg::VALUE_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= heap_mem_ff[rd_addr_a];
      rd_data_b_ff <= heap_mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> rtl/core/max_heap_priority_queue_top.sv
// Top level of the max-heap priority queue: sequencer, entry count and result register.
//
// One operation is processed at a time. An insert is accepted, then for every level that the
// new value climbs its parent is read and compared, and the result is given; the value settles
// at the root without a compare. A pop reads the root and the last entry, loads them, then for
// every level that the moved entry sinks reads and compares its children, and gives the result;
// when it takes the last entry it goes from the load straight to the result. A dropped insert or
// a pop on an empty heap goes straight to the result. The result step waits while the result
// register stays full. The pace is set by the read-compare-write loop around the entry memory,
// whose reads are registered. The heap is walked with a moving hole: the carried value is written
// once, where it settles. A finished result waits in the output register while the next item is
// accepted and worked on.
module max_heap_priority_queue_top #(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // config: max_entries
   input  logic        csr_wen,
   input  logic [8:0]  csr_wdata,
   // req_tdata: value[31:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: op[0]
   input  logic [0:0]  req_tuser,
   // rsp_tdata: popped_value[31:0], status[33:32], count_after[42:34], zero[47:43]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > hpq_pkg::CAP_W) ? CW : hpq_pkg::CAP_W;

   hpq_pkg::state_type state_ff, state_in;

   logic [hpq_pkg::CAP_W-1:0]       cap_ff;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   pos_ff, pos_in;
   logic [hpq_pkg::VALUE_W-1:0]     val_ff, val_in;
   logic [hpq_pkg::VALUE_W-1:0]     popped_ff, popped_in;
   logic [hpq_pkg::STATUS_W-1:0]    status_ff, status_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [hpq_pkg::VALUE_W-1:0]     rsp_popped_ff, rsp_popped_in;
   logic [hpq_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [hpq_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [hpq_pkg::VALUE_W-1:0]     wr_data;
   logic [AW-1:0]                   rd_addr_a;
   logic [AW-1:0]                   rd_addr_b;
   logic [hpq_pkg::VALUE_W-1:0]     rd_data_a;
   logic [hpq_pkg::VALUE_W-1:0]     rd_data_b;

   logic                            req_xfer;
   logic                            insert_ok;
   logic                            pop_ok;
   logic                            rsp_free;
   logic [CW:0]                     kid;
   logic                            kid_past_end;
   logic                            pick_right;
   logic [hpq_pkg::VALUE_W-1:0]     child_val;
   logic [CW-1:0]                   child_pos;
   logic                            climb;
   logic                            sink;

   hpq_store #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   assign req_tready = (state_ff == hpq_pkg::ST_IDLE);
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // effective capacity is min(max_entries, DEPTH)
   assign insert_ok = (XW'(count_ff) < XW'(cap_ff)) && (XW'(count_ff) < XW'(DEPTH));
   assign pop_ok = (count_ff != '0);

   assign kid = {pos_ff, 1'b0};
   assign kid_past_end = kid > (CW + 1)'(count_ff);
   assign pick_right = (kid < (CW + 1)'(count_ff)) && ($signed(rd_data_b) > $signed(rd_data_a));
   assign child_val = pick_right ? rd_data_b : rd_data_a;
   assign child_pos = pick_right ? CW'(kid + 1'b1) : CW'(kid);
   assign climb = $signed(val_ff) > $signed(rd_data_a);
   assign sink = $signed(child_val) > $signed(val_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hpq_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser[0] == hpq_pkg::OP_INSERT) begin
                  state_in = insert_ok ? hpq_pkg::ST_UP_RD : hpq_pkg::ST_RESP;
               end else begin
                  state_in = pop_ok ? hpq_pkg::ST_POP_RD : hpq_pkg::ST_RESP;
               end
            end
         end
         hpq_pkg::ST_UP_RD: begin
            state_in = (pos_ff == CW'(1)) ? hpq_pkg::ST_RESP : hpq_pkg::ST_UP_CMP;
         end
         hpq_pkg::ST_UP_CMP: begin
            state_in = climb ? hpq_pkg::ST_UP_RD : hpq_pkg::ST_RESP;
         end
         hpq_pkg::ST_POP_RD: begin
            state_in = hpq_pkg::ST_POP_LD;
         end
         hpq_pkg::ST_POP_LD: begin
            state_in = (count_ff == CW'(1)) ? hpq_pkg::ST_RESP : hpq_pkg::ST_DN_RD;
         end
         hpq_pkg::ST_DN_RD: begin
            state_in = kid_past_end ? hpq_pkg::ST_RESP : hpq_pkg::ST_DN_CMP;
         end
         hpq_pkg::ST_DN_CMP: begin
            state_in = sink ? hpq_pkg::ST_DN_RD : hpq_pkg::ST_RESP;
         end
         hpq_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = hpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      pos_in = pos_ff;
      val_in = val_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      wr_en = 1'b0;
      wr_addr = AW'(pos_ff - 1'b1);
      wr_data = val_ff;
      rd_addr_a = AW'(kid - 1'b1);
      rd_addr_b = AW'(kid);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_popped_in = rsp_popped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         hpq_pkg::ST_IDLE: begin
            if (req_xfer) begin
               val_in = req_tdata;
               popped_in = hpq_pkg::NO_VALUE;
               status_in = hpq_pkg::STATUS_DONE;
               if (req_tuser[0] == hpq_pkg::OP_INSERT) begin
                  if (insert_ok) begin
                     count_in = count_ff + 1'b1;
                     pos_in = count_ff + 1'b1;
                  end else begin
                     status_in = hpq_pkg::STATUS_FULL;
                  end
               end else if (!pop_ok) begin
                  status_in = hpq_pkg::STATUS_EMPTY;
               end
            end
         end
         hpq_pkg::ST_UP_RD: begin
            rd_addr_a = AW'((pos_ff >> 1) - 1'b1);
            // hole reached the root: settle there
            if (pos_ff == CW'(1)) begin
               wr_en = 1'b1;
            end
         end
         hpq_pkg::ST_UP_CMP: begin
            wr_en = 1'b1;
            if (climb) begin
               wr_data = rd_data_a;
               pos_in = pos_ff >> 1;
            end
         end
         hpq_pkg::ST_POP_RD: begin
            rd_addr_a = '0;
            rd_addr_b = AW'(count_ff - 1'b1);
         end
         hpq_pkg::ST_POP_LD: begin
            popped_in = rd_data_a;
            val_in = rd_data_b;
            count_in = count_ff - 1'b1;
            pos_in = CW'(1);
         end
         hpq_pkg::ST_DN_RD: begin
            if (kid_past_end) begin
               wr_en = 1'b1;
            end
         end
         hpq_pkg::ST_DN_CMP: begin
            wr_en = 1'b1;
            if (sink) begin
               wr_data = child_val;
               pos_in = child_pos;
            end
         end
         hpq_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_popped_in = popped_ff;
               rsp_status_in = status_ff;
               rsp_count_in = hpq_pkg::COUNT_OUT_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hpq_pkg::ST_IDLE;
         cap_ff <= hpq_pkg::CAP_RESET;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            cap_ff <= csr_wdata;
         end
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      val_ff <= val_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, rsp_count_ff, rsp_status_ff, rsp_popped_ff};

endmodule
